// ===== rtl/core/mtsg_pkg.sv =====
// mtsg_pkg: constants, codes, types and helper functions for the mt19937 generator
// used by mtsg_ctrl, mtsg_datapath and mt19937_seeded_generator; no dependencies
`timescale 1ns / 1ps

package mtsg_pkg;

    // store geometry
    localparam int STATE_WORDS  = 624;
    localparam int TWIST_OFFSET = 397;
    localparam int IDX_W        = 10;
    localparam int WORD_W       = 32;
    localparam int VALUE_W      = 53;
    localparam int SYM_W        = VALUE_W + 5;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [WORD_W-1:0] word_t;
    typedef logic [VALUE_W-1:0] value_t;

    localparam idx_t LAST_IDX   = idx_t'(STATE_WORDS - 1);
    localparam idx_t FAR_SPLIT  = idx_t'(STATE_WORDS - TWIST_OFFSET);
    localparam idx_t FAR_ADD    = idx_t'(TWIST_OFFSET);
    localparam idx_t WORDS_IDX  = idx_t'(STATE_WORDS);

    // generator constants
    localparam word_t TWIST_XOR   = 32'h9908_b0df;
    localparam word_t HI_BIT      = 32'h8000_0000;
    localparam word_t TEMPER_B    = 32'h9d2c_5680;
    localparam word_t TEMPER_C    = 32'hefc6_0000;
    localparam word_t INIT_MULT   = 32'd1812433253;
    localparam word_t MIX1_MULT   = 32'd1664525;
    localparam word_t MIX2_MULT   = 32'd1566083941;
    localparam word_t ARRAY_INIT  = 32'd19650218;

    // command field of an input word
    localparam logic CMD_SEED = 1'b0;
    localparam logic CMD_DRAW = 1'b1;

    // configuration register indexes
    localparam logic REG_SEED_MODE   = 1'b0;
    localparam logic REG_OUTPUT_MODE = 1'b1;

    // output modes
    localparam logic [1:0] OMODE_RAW    = 2'd0;
    localparam logic [1:0] OMODE_PAIR   = 2'd1;
    localparam logic [1:0] OMODE_SYMBOL = 2'd2;

    // fill pass codes
    localparam logic [1:0] FILL_SINGLE = 2'd0;
    localparam logic [1:0] FILL_MIX1   = 2'd1;
    localparam logic [1:0] FILL_MIX2   = 2'd2;

    // result kinds
    localparam logic [2:0] OUT_ZERO     = 3'd0;
    localparam logic [2:0] OUT_UNSEEDED = 3'd1;
    localparam logic [2:0] OUT_RAW      = 3'd2;
    localparam logic [2:0] OUT_PAIR     = 3'd3;
    localparam logic [2:0] OUT_SYMBOL   = 3'd4;

    // controller to datapath commands
    typedef struct packed {
        logic       seed_start;
        logic       use_array;
        logic       fill_mul;
        logic       fill_wr;
        logic       fill_hi;
        logic       tw_rd;
        logic       tw_far;
        logic       tw_wr;
        logic       word_sel;
        logic       sym_a;
        logic       sym_b;
        logic       out_load;
        logic [1:0] fill_kind;
        logic [2:0] out_kind;
    } mtsg_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic fill_last;
    } mtsg_sts_t;

    // output tempering
    function automatic word_t temper(input word_t w);
        word_t y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    // seeding pre-mix of the previous word
    function automatic word_t seed_mix(input word_t p);
        return p ^ (p >> 30);
    endfunction

endpackage

// ===== rtl/core/mtsg_datapath.sv =====
// mtsg_datapath: state store, seeding multiplier, on-the-fly twist, tempering and result register
// depends on mtsg_pkg; driven by mtsg_ctrl
`timescale 1ns / 1ps

module mtsg_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  mtsg_pkg::word_t    seed_value,
    input  mtsg_pkg::mtsg_cmd_t dp_cmd,
    output mtsg_pkg::mtsg_sts_t dp_sts,
    output mtsg_pkg::value_t   value,
    output logic               not_seeded
);
    import mtsg_pkg::*;

    // state store
    word_t mem [STATE_WORDS];

    word_t  rd_a_reg;
    word_t  rd_b_reg;
    word_t  prev_reg,  prev_next;
    word_t  mul_reg;
    word_t  key_reg;
    word_t  y_reg;
    word_t  word_a_reg;
    word_t  word_b_reg;
    idx_t   pos_reg,   pos_next;
    idx_t   cnt_reg,   cnt_next;
    idx_t   ridx_reg,  ridx_next;
    logic [SYM_W-1:0] sym_reg;
    value_t value_reg;
    logic   ns_reg;

    idx_t   cur_idx;
    idx_t   nx_idx;
    idx_t   far_idx;
    idx_t   raddr_a;
    idx_t   waddr;
    word_t  wdata;
    logic   we;
    word_t  mult_k;
    logic [2*WORD_W-1:0] prod;
    word_t  fill_w;
    word_t  tw_w;
    word_t  tw_t;
    value_t pair;
    idx_t   fill_limit;

    // index arithmetic for the twist
    always_comb
    begin
        cur_idx = (ridx_reg >= WORDS_IDX) ? '0 : ridx_reg;
        nx_idx  = (cur_idx == LAST_IDX) ? '0 : cur_idx + idx_t'(1);
        far_idx = (ridx_reg < FAR_SPLIT) ? ridx_reg + FAR_ADD : ridx_reg - FAR_SPLIT;
    end

    // seeding multiplier constant and product
    always_comb
    begin
        case (dp_cmd.fill_kind)
            FILL_SINGLE: mult_k = INIT_MULT;
            FILL_MIX1:   mult_k = MIX1_MULT;
            FILL_MIX2:   mult_k = MIX2_MULT;
            default:     mult_k = INIT_MULT;
        endcase
        prod = seed_mix(prev_reg) * mult_k;
    end

    // new word of the current fill pass
    always_comb
    begin
        case (dp_cmd.fill_kind)
            FILL_SINGLE: fill_w = mul_reg + word_t'(pos_reg);
            FILL_MIX1:   fill_w = (rd_a_reg ^ mul_reg) + key_reg;
            FILL_MIX2:   fill_w = (rd_a_reg ^ mul_reg) - word_t'(pos_reg);
            default:     fill_w = mul_reg;
        endcase
        case (dp_cmd.fill_kind)
            FILL_SINGLE: fill_limit = idx_t'(STATE_WORDS - 2);
            FILL_MIX1:   fill_limit = idx_t'(STATE_WORDS - 1);
            FILL_MIX2:   fill_limit = idx_t'(STATE_WORDS - 2);
            default:     fill_limit = idx_t'(STATE_WORDS - 2);
        endcase
        dp_sts.fill_last = (cnt_reg == fill_limit);
    end

    // twisted word and its tempered form
    always_comb
    begin
        tw_w = rd_a_reg ^ (y_reg >> 1) ^ (y_reg[0] ? TWIST_XOR : '0);
        tw_t = temper(tw_w);
        pair = {word_a_reg[WORD_W-1:5], word_b_reg[WORD_W-1:6]};
    end

    // store port selection
    always_comb
    begin
        we      = 1'b0;
        waddr   = pos_reg;
        wdata   = fill_w;
        raddr_a = pos_reg;
        if (dp_cmd.seed_start)
        begin
            we    = 1'b1;
            waddr = '0;
            wdata = dp_cmd.use_array ? ARRAY_INIT : seed_value;
        end
        else if (dp_cmd.fill_wr)
        begin
            we = 1'b1;
        end
        else if (dp_cmd.fill_hi)
        begin
            we    = 1'b1;
            waddr = '0;
            wdata = HI_BIT;
        end
        else if (dp_cmd.tw_wr)
        begin
            we    = 1'b1;
            waddr = ridx_reg;
            wdata = tw_w;
        end
        if (dp_cmd.tw_rd)
        begin
            raddr_a = cur_idx;
        end
        else if (dp_cmd.tw_far)
        begin
            raddr_a = far_idx;
        end
    end

    // store write and registered reads
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_a_reg <= mem[raddr_a];
        rd_b_reg <= mem[nx_idx];
    end

    // counters and previous word
    always_comb
    begin
        prev_next = prev_reg;
        pos_next  = pos_reg;
        cnt_next  = cnt_reg;
        ridx_next = ridx_reg;
        if (dp_cmd.seed_start)
        begin
            prev_next = dp_cmd.use_array ? ARRAY_INIT : seed_value;
            pos_next  = idx_t'(1);
            cnt_next  = '0;
            ridx_next = WORDS_IDX;
        end
        else if (dp_cmd.fill_wr)
        begin
            prev_next = fill_w;
            pos_next  = (pos_reg == LAST_IDX) ? idx_t'(1) : pos_reg + idx_t'(1);
            cnt_next  = dp_sts.fill_last ? '0 : cnt_reg + idx_t'(1);
            // the first mixing pass starts from the initial word, not the last one written
            if (dp_sts.fill_last && dp_cmd.fill_kind == FILL_SINGLE)
            begin
                prev_next = ARRAY_INIT;
            end
        end
        else if (dp_cmd.tw_rd)
        begin
            ridx_next = cur_idx;
        end
        else if (dp_cmd.tw_wr)
        begin
            ridx_next = ridx_reg + idx_t'(1);
        end
    end

    // control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= idx_t'(1);
            cnt_reg  <= '0;
            ridx_reg <= WORDS_IDX;
        end
        else
        begin
            pos_reg  <= pos_next;
            cnt_reg  <= cnt_next;
            ridx_reg <= ridx_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        prev_reg <= prev_next;
        if (dp_cmd.seed_start)
        begin
            key_reg <= seed_value;
        end
        if (dp_cmd.fill_mul)
        begin
            mul_reg <= prod[WORD_W-1:0];
        end
        if (dp_cmd.tw_far)
        begin
            y_reg <= {rd_a_reg[WORD_W-1], rd_b_reg[WORD_W-2:0]};
        end
        if (dp_cmd.tw_wr && !dp_cmd.word_sel)
        begin
            word_a_reg <= tw_t;
        end
        if (dp_cmd.tw_wr && dp_cmd.word_sel)
        begin
            word_b_reg <= tw_t;
        end
        // symbol: 29v built as 32v - v - 2v, in ST_SYMA and then ST_SYMB
        if (dp_cmd.sym_a)
        begin
            sym_reg <= {pair, 5'b0} - {5'b0, pair};
        end
        else if (dp_cmd.sym_b)
        begin
            sym_reg <= sym_reg - {4'b0, pair, 1'b0};
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (dp_cmd.out_load)
        begin
            case (dp_cmd.out_kind)
                OUT_ZERO:
                begin
                    value_reg <= '0;
                    ns_reg    <= 1'b0;
                end
                OUT_UNSEEDED:
                begin
                    value_reg <= '0;
                    ns_reg    <= 1'b1;
                end
                OUT_RAW:
                begin
                    value_reg <= value_t'(word_a_reg);
                    ns_reg    <= 1'b0;
                end
                OUT_PAIR:
                begin
                    value_reg <= pair;
                    ns_reg    <= 1'b0;
                end
                OUT_SYMBOL:
                begin
                    value_reg <= value_t'(sym_reg[SYM_W-1:VALUE_W]);
                    ns_reg    <= 1'b0;
                end
                default:
                begin
                    value_reg <= '0;
                    ns_reg    <= 1'b0;
                end
            endcase
        end
    end

    assign value      = value_reg;
    assign not_seeded = ns_reg;

endmodule

// ===== rtl/core/mtsg_ctrl.sv =====
// mtsg_ctrl: sequencing state machine for seeding, twisting draws and result hand-off
// depends on mtsg_pkg; commands mtsg_datapath
`timescale 1ns / 1ps

module mtsg_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic                cmd,
    input  logic                seed_mode,
    input  logic [1:0]          output_mode,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output mtsg_pkg::mtsg_cmd_t dp_cmd,
    input  mtsg_pkg::mtsg_sts_t dp_sts
);
    import mtsg_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_FMUL = 4'd1;
    localparam logic [3:0] ST_FWR  = 4'd2;
    localparam logic [3:0] ST_FHI  = 4'd3;
    localparam logic [3:0] ST_TRD  = 4'd4;
    localparam logic [3:0] ST_TFAR = 4'd5;
    localparam logic [3:0] ST_TWR  = 4'd6;
    localparam logic [3:0] ST_SYMA = 4'd7;
    localparam logic [3:0] ST_SYMB = 4'd8;
    localparam logic [3:0] ST_DONE = 4'd9;

    logic [3:0] state_reg,     state_next;
    logic       seeded_reg,    seeded_next;
    logic       rsp_valid_reg, rsp_valid_next;
    logic [1:0] fill_kind_reg, fill_kind_next;
    logic [2:0] out_kind_reg,  out_kind_next;
    logic       word_sel_reg,  word_sel_next;
    logic       slot_free;

    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

    // next state and datapath commands
    always_comb
    begin
        state_next     = state_reg;
        seeded_next    = seeded_reg;
        fill_kind_next = fill_kind_reg;
        out_kind_next  = out_kind_reg;
        word_sel_next  = word_sel_reg;
        rsp_valid_next = rsp_ready ? 1'b0 : rsp_valid_reg;
        dp_cmd           = '0;
        dp_cmd.fill_kind = fill_kind_reg;
        dp_cmd.out_kind  = out_kind_reg;
        dp_cmd.word_sel  = word_sel_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (cmd == CMD_SEED)
                    begin
                        dp_cmd.seed_start = 1'b1;
                        dp_cmd.use_array  = seed_mode;
                        seeded_next       = 1'b1;
                        fill_kind_next    = FILL_SINGLE;
                        out_kind_next     = OUT_ZERO;
                        state_next        = ST_FMUL;
                    end
                    else if (!seeded_reg)
                    begin
                        out_kind_next = OUT_UNSEEDED;
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        word_sel_next = 1'b0;
                        case (output_mode)
                            OMODE_RAW:  out_kind_next = OUT_RAW;
                            OMODE_PAIR: out_kind_next = OUT_PAIR;
                            default:    out_kind_next = OUT_SYMBOL;
                        endcase
                        state_next = ST_TRD;
                    end
                end
            end
            ST_FMUL:
            begin
                dp_cmd.fill_mul = 1'b1;
                state_next      = ST_FWR;
            end
            ST_FWR:
            begin
                dp_cmd.fill_wr = 1'b1;
                state_next     = ST_FMUL;
                if (dp_sts.fill_last)
                begin
                    case (fill_kind_reg)
                        FILL_SINGLE:
                        begin
                            if (seed_mode)
                            begin
                                fill_kind_next = FILL_MIX1;
                            end
                            else
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        FILL_MIX1: fill_kind_next = FILL_MIX2;
                        default:   state_next     = ST_FHI;
                    endcase
                end
            end
            ST_FHI:
            begin
                dp_cmd.fill_hi = 1'b1;
                state_next     = ST_DONE;
            end
            ST_TRD:
            begin
                dp_cmd.tw_rd = 1'b1;
                state_next   = ST_TFAR;
            end
            ST_TFAR:
            begin
                dp_cmd.tw_far = 1'b1;
                state_next    = ST_TWR;
            end
            ST_TWR:
            begin
                dp_cmd.tw_wr = 1'b1;
                if (out_kind_reg == OUT_RAW || word_sel_reg)
                begin
                    state_next = (out_kind_reg == OUT_SYMBOL) ? ST_SYMA : ST_DONE;
                end
                else
                begin
                    word_sel_next = 1'b1;
                    state_next    = ST_TRD;
                end
            end
            ST_SYMA:
            begin
                dp_cmd.sym_a = 1'b1;
                state_next   = ST_SYMB;
            end
            ST_SYMB:
            begin
                dp_cmd.sym_b = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    dp_cmd.out_load = 1'b1;
                    rsp_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seeded_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
            fill_kind_reg <= FILL_SINGLE;
            out_kind_reg  <= OUT_ZERO;
            word_sel_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seeded_reg    <= seeded_next;
            rsp_valid_reg <= rsp_valid_next;
            fill_kind_reg <= fill_kind_next;
            out_kind_reg  <= out_kind_next;
            word_sel_reg  <= word_sel_next;
        end
    end

endmodule

// ===== rtl/core/mt19937_seeded_generator.sv =====
// mt19937_seeded_generator: top level, configuration registers and the ctrl/datapath pair
// depends on mtsg_pkg, mtsg_ctrl and mtsg_datapath
//
// request channel (req_valid/req_ready) carries one word: cmd and seed_value.
//   cmd 0 seeds the 624-word store (single-seed or one-key array rule per seed_mode),
//   cmd 1 draws one result in the form chosen by output_mode.
// response channel (rsp_valid/rsp_ready) carries one word per request: value and not_seeded.
// sequence, request accept to response valid: a raw draw steps through TRD, TFAR, TWR
//   and DONE, a 53-bit draw runs TRD, TFAR and TWR for each of its words, a symbol draw adds
//   SYMA and SYMB, a draw before any seed goes straight to DONE; seeding runs the FILL_SINGLE
//   pass, an array seed then MIX1, MIX2 and FHI; req_ready is high again as rsp_valid rises.
// every draw twists its store words on the fly: one three-read, one-write pass
// per word through the two-read single-write state store, which sets the draw time;
// seeding runs an FMUL and an FWR state per word through one shared 32x32 multiplier.
// one request is worked on at a time; a finished response sits in the output register,
// so the next request is taken while the receiver stalls, and finishes once it drains.
// configuration writes (cfg_we, cfg_index, cfg_data) take effect at once; make them idle.
// reset clears the seeded flag, empties the response register and sets seed_mode 1,
// output_mode 2; the store contents are undefined until the first seed.
`timescale 1ns / 1ps

module mt19937_seeded_generator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic                cmd,
    input  mtsg_pkg::word_t     seed_value,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output mtsg_pkg::value_t    value,
    output logic                not_seeded,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [1:0]          cfg_data
);
    import mtsg_pkg::*;

    logic       seed_mode_reg,   seed_mode_next;
    logic [1:0] output_mode_reg, output_mode_next;
    mtsg_cmd_t  dp_cmd;
    mtsg_sts_t  dp_sts;

    // configuration register writes
    always_comb
    begin
        seed_mode_next   = seed_mode_reg;
        output_mode_next = output_mode_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_SEED_MODE:   seed_mode_next   = cfg_data[0];
                REG_OUTPUT_MODE: output_mode_next = cfg_data;
                default:         seed_mode_next   = seed_mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_mode_reg   <= 1'b1;
            output_mode_reg <= OMODE_SYMBOL;
        end
        else
        begin
            seed_mode_reg   <= seed_mode_next;
            output_mode_reg <= output_mode_next;
        end
    end

    // sequencer
    mtsg_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .cmd         (cmd),
        .seed_mode   (seed_mode_reg),
        .output_mode (output_mode_reg),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .dp_cmd      (dp_cmd),
        .dp_sts      (dp_sts)
    );

    // store and arithmetic
    mtsg_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed_value (seed_value),
        .dp_cmd     (dp_cmd),
        .dp_sts     (dp_sts),
        .value      (value),
        .not_seeded (not_seeded)
    );

endmodule
